FILE: rtl/mqmr_pkg.sv
// ----------------------------------------------------------------------------
// mqmr_pkg
// Shared types and constants for the multi-queue message ring.
// ----------------------------------------------------------------------------
`default_nettype none

package mqmr_pkg;

  localparam int NUM_QUEUES_DEF = 8;
  localparam int QUEUE_LEN_DEF  = 16;
  localparam int MSG_WIDTH_DEF  = 64;

  localparam int QID_W  = 3;
  localparam int DATA_W = 64;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_t;

  typedef struct packed {
    func_t              func;
    logic [QID_W-1:0]   queue_id;
    logic [DATA_W-1:0]  msg_data;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [DATA_W-1:0]  msg_out;
  } rsp_t;

endpackage

`default_nettype wire

FILE: rtl/mqmr_ram.sv
// ----------------------------------------------------------------------------
// mqmr_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mqmr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/multi_queue_message_ring_unit.sv
// ----------------------------------------------------------------------------
// multi_queue_message_ring_unit
// Bank of independent message FIFOs with push and pop on one request channel.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req_item) carries one push or pop on
//   one queue. rsp channel (rsp_valid / rsp_stall / rsp_item) returns exactly
//   one result per request, in order: ok, and the popped message for a pop.
//   Queue counters and slot pointers live in a small state RAM, messages in
//   a message RAM; both have registered read data.
//   A push, a refused pop or an out-of-range queue goes from the lookup state
//   to the response state; a successful pop reads the message RAM in a read
//   state between them. Each request is paced by the read-modify-write of the
//   state RAM, followed for a pop by the message RAM read.
//   One request is in flight at a time; req_stall is high while it works.
//   A result waiting under rsp_stall does not block the next acceptance; the
//   next result waits until the output register is taken.
//   Reset: all queues read as empty with both slots at one, by per-queue
//   valid bits; no clearing pass is needed. The message RAM is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_queue_message_ring_unit #(
  parameter int NUM_QUEUES = mqmr_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_LEN  = mqmr_pkg::QUEUE_LEN_DEF,
  parameter int MSG_WIDTH  = mqmr_pkg::MSG_WIDTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire mqmr_pkg::req_t req_item,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output mqmr_pkg::rsp_t     rsp_item
);

  import mqmr_pkg::*;

  localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int QIW    = (QW > QID_W) ? QW : QID_W;
  localparam int SW     = $clog2(QUEUE_LEN);
  localparam int WW     = 3 * SW;
  localparam int MDEPTH = NUM_QUEUES * QUEUE_LEN;
  localparam int MAW    = $clog2(MDEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_READ,
    S_RESP
  } state_t;

  state_t               state;
  logic [NUM_QUEUES-1:0] qinit;

  // request registers
  func_t                func_r;
  logic [QW-1:0]        q_r;
  logic [MSG_WIDTH-1:0] data_r;
  logic                 in_range_r;
  logic                 qinit_r;
  logic                 ok_r;
  logic [MSG_WIDTH-1:0] msg_hold;

  logic [QIW-1:0]       qid_ext;
  logic [QW-1:0]        q_idx;
  logic                 in_range;

  logic [WW-1:0]        st_rdata;
  logic [WW-1:0]        st_word;
  logic [WW-1:0]        st_wdata;
  logic                 st_we;
  logic [SW-1:0]        cur_cnt;
  logic [SW-1:0]        cur_rd;
  logic [SW-1:0]        cur_wr;
  logic [SW-1:0]        nxt_rd;
  logic [SW-1:0]        nxt_wr;
  logic                 push_ok;
  logic                 pop_ok;

  logic                 msg_we;
  logic [MAW-1:0]       msg_waddr;
  logic [MAW-1:0]       msg_raddr;
  logic [MSG_WIDTH-1:0] msg_rdata;
  logic                 out_free;

  assign qid_ext  = QIW'(req_item.queue_id);
  assign q_idx    = qid_ext[QW-1:0];
  assign in_range = int'(req_item.queue_id) < NUM_QUEUES;

  assign req_stall = (state != S_IDLE);
  assign out_free  = !rsp_valid || !rsp_stall;

  // queue state word: count, read slot, write slot
  assign st_word = qinit_r ? st_rdata : {SW'(0), SW'(1), SW'(1)};
  assign cur_cnt = st_word[3*SW-1:2*SW];
  assign cur_rd  = st_word[2*SW-1:SW];
  assign cur_wr  = st_word[SW-1:0];

  // slot 0 is reserved, so wrap to slot 1
  assign nxt_rd = (cur_rd == SW'(QUEUE_LEN - 1)) ? SW'(1) : cur_rd + SW'(1);
  assign nxt_wr = (cur_wr == SW'(QUEUE_LEN - 1)) ? SW'(1) : cur_wr + SW'(1);

  assign push_ok = in_range_r && (func_r == FUNC_PUSH) && (cur_cnt != SW'(QUEUE_LEN - 1));
  assign pop_ok  = in_range_r && (func_r == FUNC_POP) && (cur_cnt != SW'(0));

  always_comb begin
    st_wdata = st_word;
    if (push_ok) begin
      st_wdata = {cur_cnt + SW'(1), cur_rd, nxt_wr};
    end else if (pop_ok) begin
      st_wdata = {cur_cnt - SW'(1), nxt_rd, cur_wr};
    end
  end

  assign st_we  = (state == S_LOOKUP) && (push_ok || pop_ok);
  assign msg_we = (state == S_LOOKUP) && push_ok;

  assign msg_waddr = MAW'(q_r) * MAW'(QUEUE_LEN) + MAW'(cur_wr);
  assign msg_raddr = MAW'(q_r) * MAW'(QUEUE_LEN) + MAW'(cur_rd);

  mqmr_ram #(
    .WIDTH (WW),
    .DEPTH (NUM_QUEUES)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (q_r),
    .wdata (st_wdata),
    .raddr (q_idx),
    .rdata (st_rdata)
  );

  mqmr_ram #(
    .WIDTH (MSG_WIDTH),
    .DEPTH (MDEPTH)
  ) u_msg_ram (
    .clk   (clk),
    .we    (msg_we),
    .waddr (msg_waddr),
    .wdata (data_r),
    .raddr (msg_raddr),
    .rdata (msg_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      qinit     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if ((state == S_RESP) && out_free) begin
        rsp_valid        <= 1'b1;
        rsp_item.ok      <= ok_r;
        rsp_item.msg_out <= DATA_W'(msg_hold);
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            func_r     <= req_item.func;
            q_r        <= q_idx;
            data_r     <= req_item.msg_data[MSG_WIDTH-1:0];
            in_range_r <= in_range;
            qinit_r    <= qinit[q_idx];
            state      <= S_LOOKUP;
          end
        end
        S_LOOKUP: begin
          ok_r     <= push_ok || pop_ok;
          msg_hold <= '0;
          if (push_ok || pop_ok) begin
            qinit[q_r] <= 1'b1;
          end
          state <= pop_ok ? S_READ : S_RESP;
        end
        S_READ: begin
          msg_hold <= msg_rdata;
          state    <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mqmr_checker.sv
// ----------------------------------------------------------------------------
// mqmr_checker
// Port-level checks for the multi-queue message ring, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mqmr_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_stall,
  input wire mqmr_pkg::req_t req_item,
  input wire logic           rsp_valid,
  input wire logic           rsp_stall,
  input wire mqmr_pkg::rsp_t rsp_item
);

  import mqmr_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
    else $error("stalled response changed");

  // a refused transaction carries no message
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_item.ok |-> rsp_item.msg_out == '0)
    else $error("refused transaction with nonzero message");

  // one transaction in flight: the request side closes right after acceptance
  a_one_inflight: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("second transaction accepted while busy");

  // a result only appears while a transaction is being worked on
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(req_stall))
    else $error("response with no transaction in flight");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind multi_queue_message_ring_unit mqmr_checker u_mqmr_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_stall (req_stall),
  .req_item  (req_item),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_item  (rsp_item)
);

`default_nettype wire
